@@ sv/eevdf_pkg.sv @@
`timescale 1ns / 1ps

package eevdf_pkg;

  localparam int unsigned SLICE_W     = 8;
  localparam int unsigned UNIT_SHIFT  = 10;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned DIV_W       = SLICE_W + UNIT_SHIFT;
  localparam int unsigned VR_W        = 32;
  localparam int unsigned DL_W        = 33;
  localparam int unsigned NICE_W      = 6;
  localparam logic [NICE_W-1:0] NICE_MAX     = 6'd39;
  localparam logic [NICE_W-1:0] NICE_DEFAULT = 6'd20;
  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd5;

  typedef enum logic [1:0] {
    OP_SET_VRUNTIME = 2'd0,
    OP_SET_STATUS   = 2'd1,
    OP_SET_NICE     = 2'd2,
    OP_PICK         = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_INACTIVE = 2'd0,
    ST_SLEEPING = 2'd1,
    ST_RUNNABLE = 2'd2,
    ST_RUNNING  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_WR,
    S_MIN,
    S_LAG,
    S_SEL,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [5:0]        slot;
    logic [VR_W-1:0]   vruntime;
    logic [1:0]        status;
    logic              refresh_deadline;
    logic [NICE_W-1:0] nice_level;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [5:0]        chosen_slot;
    logic [NICE_W-1:0] prev_nice;
    logic [DL_W-1:0]   chosen_deadline;
  } out_item_t;

  typedef struct packed {
    status_e           status;
    logic [NICE_W-1:0] nice;
    logic [VR_W-1:0]   vruntime;
    logic [DL_W-1:0]   deadline;
  } row_t;

  localparam row_t ROW_RESET = '{
    status:   ST_INACTIVE,
    nice:     NICE_DEFAULT,
    vruntime: '0,
    deadline: '0
  };

  // Weight of a nice level; levels above the table saturate to the last entry.
  function automatic logic [WEIGHT_W-1:0] weight_of(logic [NICE_W-1:0] n);
    logic [WEIGHT_W-1:0] w;
    case (n)
      6'd0:  w = 17'd88818;
      6'd1:  w = 17'd71054;
      6'd2:  w = 17'd56843;
      6'd3:  w = 17'd45475;
      6'd4:  w = 17'd36380;
      6'd5:  w = 17'd29104;
      6'd6:  w = 17'd23283;
      6'd7:  w = 17'd18626;
      6'd8:  w = 17'd14901;
      6'd9:  w = 17'd11921;
      6'd10: w = 17'd9537;
      6'd11: w = 17'd7629;
      6'd12: w = 17'd6104;
      6'd13: w = 17'd4883;
      6'd14: w = 17'd3906;
      6'd15: w = 17'd3125;
      6'd16: w = 17'd2500;
      6'd17: w = 17'd2000;
      6'd18: w = 17'd1600;
      6'd19: w = 17'd1280;
      6'd20: w = 17'd1024;
      6'd21: w = 17'd819;
      6'd22: w = 17'd655;
      6'd23: w = 17'd524;
      6'd24: w = 17'd419;
      6'd25: w = 17'd336;
      6'd26: w = 17'd268;
      6'd27: w = 17'd215;
      6'd28: w = 17'd172;
      6'd29: w = 17'd137;
      6'd30: w = 17'd110;
      6'd31: w = 17'd88;
      6'd32: w = 17'd70;
      6'd33: w = 17'd56;
      6'd34: w = 17'd45;
      6'd35: w = 17'd36;
      6'd36: w = 17'd29;
      6'd37: w = 17'd23;
      6'd38: w = 17'd18;
      default: w = 17'd15;
    endcase
    return w;
  endfunction

endpackage

@@ sv/eevdf_task_picker.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i/in_stall_o    eevdf_pkg::in_item_t
// out      output     out_valid_o/out_stall_i  eevdf_pkg::out_item_t
// cfg      input      cfg_valid_i/cfg_ready_o  cfg_data_i (slice_ticks)
//
// A set_vruntime, or a set_status that keeps the deadline, skips the divider; a
// set_status that renews the deadline and a set_nice pass through the 18-step
// restoring divider that forms slice*1024/weight.
// A pick makes three walks over the slot memory, one read per cycle, feeding one
// shared multiplier.
// One item is in work at a time; a finished result waits in the output
// register while the next item is taken. Reset clears all slots via valid bits.
module eevdf_task_picker #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  eevdf_pkg::in_item_t      in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output eevdf_pkg::out_item_t     out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [7:0]               cfg_data_i
);

  localparam int unsigned SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IW  = SW + 1;
  localparam int unsigned WSW = eevdf_pkg::WEIGHT_W + $clog2(SLOTS + 1);
  localparam int unsigned PW  = eevdf_pkg::VR_W + WSW;
  localparam int unsigned CW  = $clog2(eevdf_pkg::DIV_W);
  localparam logic [IW-1:0] SLOTS_I = IW'(SLOTS);
  localparam logic [CW-1:0] DIV_LAST = CW'(eevdf_pkg::DIV_W - 1);

  eevdf_pkg::state_e state_q, state_d;

  logic [7:0]           slice_q;
  eevdf_pkg::in_item_t  req_q;
  eevdf_pkg::row_t      wrow_q;
  logic                 upd_dl_q;
  logic [5:0]           prev_nice_q;
  eevdf_pkg::out_item_t out_q;
  logic                 out_valid_q;

  // Slot memory and its valid bits.
  eevdf_pkg::row_t mem [SLOTS];
  logic [SLOTS-1:0] vld_q;
  eevdf_pkg::row_t  rd_row_q;
  logic             rd_ok_q;
  logic [SW-1:0]    rd_addr;
  logic             mem_we;
  logic [SW-1:0]    wr_addr;
  eevdf_pkg::row_t  wr_row;
  eevdf_pkg::row_t  eff_row;

  // Divider.
  logic [eevdf_pkg::DIV_W-1:0]    rem_q, quo_q;
  logic [eevdf_pkg::WEIGHT_W-1:0] dvs_q;
  logic [CW-1:0]                  cnt_q;
  logic [eevdf_pkg::DIV_W:0]      rem_sh;
  logic                           div_ge;

  // Walk pipeline.
  logic [IW-1:0]    idx_q;
  logic             issue;
  logic             s1_q, s2_q;
  logic [SW-1:0]    s1_idx_q, s2_idx_q;
  eevdf_pkg::row_t  s2_row_q;
  logic [eevdf_pkg::WEIGHT_W-1:0] s2_w_q;
  logic             s2_act_q, s2_run_q;
  logic [PW-1:0]    prod_q, prod_c;
  logic [WSW-1:0]   mul_b;
  logic [eevdf_pkg::VR_W-1:0] diff1;
  logic             pass_done;
  logic             walking;

  logic [eevdf_pkg::VR_W-1:0] minv_q;
  logic [WSW-1:0]   wsum_q;
  logic             any_q;
  logic [PW-1:0]    lag_q;
  logic             have_q;
  logic [SW-1:0]    best_idx_q;
  eevdf_pkg::row_t  best_row_q;

  logic in_acc, slot_ok, out_free, elig, pick_hit;
  logic [eevdf_pkg::NICE_W-1:0] nice_sat;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign slot_ok  = {3'b0, in_item_i.slot} < 9'(SLOTS);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign issue     = idx_q < SLOTS_I;
  assign pass_done = !issue && !s1_q && !s2_q;
  assign walking   = (state_q == eevdf_pkg::S_MIN) || (state_q == eevdf_pkg::S_LAG) ||
                     (state_q == eevdf_pkg::S_SEL);
  assign nice_sat  = (req_q.nice_level > eevdf_pkg::NICE_MAX) ? eevdf_pkg::NICE_MAX
                                                                : req_q.nice_level;
  assign pick_hit  = (eevdf_pkg::op_e'(req_q.op) == eevdf_pkg::OP_PICK) && have_q;

  assign eff_row = rd_ok_q ? rd_row_q : eevdf_pkg::ROW_RESET;
  assign diff1   = eff_row.vruntime - minv_q;
  assign mul_b   = (state_q == eevdf_pkg::S_LAG) ? WSW'(eevdf_pkg::weight_of(eff_row.nice))
                                                 : wsum_q;
  assign prod_c  = PW'(diff1) * PW'(mul_b);

  assign rem_sh = {rem_q, quo_q[eevdf_pkg::DIV_W-1]};
  assign div_ge = rem_sh >= (eevdf_pkg::DIV_W + 1)'(dvs_q);

  assign elig = (wsum_q == '0) || (prod_q <= lag_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      eevdf_pkg::S_IDLE: begin
        if (in_acc) begin
          if (eevdf_pkg::op_e'(in_item_i.op) == eevdf_pkg::OP_PICK) begin
            state_d = eevdf_pkg::S_MIN;
          end else if (slot_ok) begin
            state_d = eevdf_pkg::S_EXEC;
          end else begin
            state_d = eevdf_pkg::S_DONE;
          end
        end
      end
      eevdf_pkg::S_EXEC: begin
        unique case (eevdf_pkg::op_e'(req_q.op))
          eevdf_pkg::OP_SET_STATUS: begin
            if ((eff_row.status == eevdf_pkg::ST_SLEEPING &&
                 eevdf_pkg::status_e'(req_q.status) == eevdf_pkg::ST_RUNNABLE) ||
                req_q.refresh_deadline) begin
              state_d = eevdf_pkg::S_DIV;
            end else begin
              state_d = eevdf_pkg::S_WR;
            end
          end
          eevdf_pkg::OP_SET_NICE: state_d = eevdf_pkg::S_DIV;
          default: state_d = eevdf_pkg::S_WR;
        endcase
      end
      eevdf_pkg::S_DIV: if (cnt_q == DIV_LAST) state_d = eevdf_pkg::S_WR;
      eevdf_pkg::S_WR:  state_d = eevdf_pkg::S_DONE;
      eevdf_pkg::S_MIN: if (pass_done) state_d = eevdf_pkg::S_LAG;
      eevdf_pkg::S_LAG: if (pass_done) state_d = eevdf_pkg::S_SEL;
      eevdf_pkg::S_SEL: if (pass_done) state_d = eevdf_pkg::S_FIN;
      eevdf_pkg::S_FIN: state_d = eevdf_pkg::S_DONE;
      eevdf_pkg::S_DONE: if (out_free) state_d = eevdf_pkg::S_IDLE;
      default: state_d = eevdf_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and memory port control.
  always_comb begin
    in_stall_o = 1'b1;
    rd_addr    = idx_q[SW-1:0];
    mem_we     = 1'b0;
    wr_addr    = SW'(req_q.slot);
    wr_row     = wrow_q;
    unique case (state_q)
      eevdf_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        rd_addr    = SW'(in_item_i.slot);
      end
      eevdf_pkg::S_WR: begin
        mem_we = 1'b1;
        if (upd_dl_q) begin
          wr_row.deadline = {1'b0, wrow_q.vruntime} + eevdf_pkg::DL_W'(quo_q);
        end
      end
      eevdf_pkg::S_FIN: begin
        mem_we         = have_q;
        wr_addr        = best_idx_q;
        wr_row         = best_row_q;
        wr_row.status  = eevdf_pkg::ST_RUNNING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_row;
    end
    rd_row_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= eevdf_pkg::S_IDLE;
      slice_q     <= eevdf_pkg::SLICE_RESET;
      vld_q       <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      cnt_q       <= '0;
      upd_dl_q    <= 1'b0;
      have_q      <= 1'b0;
      any_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= vld_q[rd_addr];
      if (cfg_valid_i && cfg_ready_o) begin
        slice_q <= cfg_data_i;
      end
      if (mem_we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (state_q == eevdf_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      s1_q <= walking && issue;
      s2_q <= s1_q;
      unique case (state_q)
        eevdf_pkg::S_IDLE: begin
          idx_q    <= '0;
          upd_dl_q <= 1'b0;
          have_q   <= 1'b0;
          any_q    <= 1'b0;
        end
        eevdf_pkg::S_EXEC: begin
          cnt_q    <= '0;
          upd_dl_q <= (state_d == eevdf_pkg::S_DIV);
        end
        eevdf_pkg::S_DIV: cnt_q <= cnt_q + 1'b1;
        eevdf_pkg::S_MIN, eevdf_pkg::S_LAG, eevdf_pkg::S_SEL: begin
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end else if (pass_done) begin
            idx_q <= '0;
          end
          if (state_q == eevdf_pkg::S_MIN && s2_q && s2_act_q) begin
            any_q <= 1'b1;
          end
          if (state_q == eevdf_pkg::S_SEL && s2_q && s2_run_q && elig &&
              (!have_q || s2_row_q.deadline < best_row_q.deadline)) begin
            have_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_item_i;
    end
    s1_idx_q <= rd_addr;
    s2_idx_q <= s1_idx_q;
    s2_row_q <= eff_row;
    s2_w_q   <= eevdf_pkg::weight_of(eff_row.nice);
    s2_act_q <= (eff_row.status == eevdf_pkg::ST_RUNNABLE) ||
                (eff_row.status == eevdf_pkg::ST_RUNNING);
    s2_run_q <= (eff_row.status == eevdf_pkg::ST_RUNNABLE);
    prod_q   <= prod_c;

    unique case (state_q)
      eevdf_pkg::S_IDLE: begin
        minv_q      <= '1;
        wsum_q      <= '0;
        lag_q       <= '0;
        prev_nice_q <= '0;
      end
      eevdf_pkg::S_EXEC: begin
        rem_q  <= '0;
        quo_q  <= {slice_q, {eevdf_pkg::UNIT_SHIFT{1'b0}}};
        unique case (eevdf_pkg::op_e'(req_q.op))
          eevdf_pkg::OP_SET_VRUNTIME: begin
            wrow_q <= '{status: eff_row.status, nice: eff_row.nice,
                        vruntime: req_q.vruntime, deadline: eff_row.deadline};
            dvs_q  <= eevdf_pkg::weight_of(eff_row.nice);
          end
          eevdf_pkg::OP_SET_STATUS: begin
            wrow_q <= '{status: eevdf_pkg::status_e'(req_q.status), nice: eff_row.nice,
                        vruntime: eff_row.vruntime, deadline: eff_row.deadline};
            dvs_q  <= eevdf_pkg::weight_of(eff_row.nice);
          end
          eevdf_pkg::OP_SET_NICE: begin
            prev_nice_q <= eff_row.nice;
            wrow_q      <= '{status: eff_row.status, nice: nice_sat,
                             vruntime: eff_row.vruntime, deadline: eff_row.deadline};
            dvs_q       <= eevdf_pkg::weight_of(nice_sat);
          end
          default: begin
            wrow_q <= eff_row;
            dvs_q  <= eevdf_pkg::weight_of(eff_row.nice);
          end
        endcase
      end
      eevdf_pkg::S_DIV: begin
        rem_q <= div_ge ? eevdf_pkg::DIV_W'(rem_sh - (eevdf_pkg::DIV_W + 1)'(dvs_q))
                        : eevdf_pkg::DIV_W'(rem_sh);
        quo_q <= {quo_q[eevdf_pkg::DIV_W-2:0], div_ge};
      end
      eevdf_pkg::S_MIN: begin
        if (s2_q && s2_act_q) begin
          wsum_q <= wsum_q + WSW'(s2_w_q);
          if (s2_row_q.vruntime < minv_q) begin
            minv_q <= s2_row_q.vruntime;
          end
        end else if (pass_done && !any_q) begin
          // With no active slot the minimum counts as zero.
          minv_q <= '0;
        end
      end
      eevdf_pkg::S_LAG: begin
        if (s2_q && s2_act_q) begin
          lag_q <= lag_q + prod_q;
        end
      end
      eevdf_pkg::S_SEL: begin
        if (s2_q && s2_run_q && elig &&
            (!have_q || s2_row_q.deadline < best_row_q.deadline)) begin
          best_idx_q <= s2_idx_q;
          best_row_q <= s2_row_q;
        end
      end
      eevdf_pkg::S_DONE: begin
        if (out_free) begin
          out_q.found           <= pick_hit;
          out_q.chosen_slot     <= pick_hit ? 6'(best_idx_q) : '0;
          out_q.prev_nice       <= prev_nice_q;
          out_q.chosen_deadline <= pick_hit ? best_row_q.deadline : '0;
        end
      end
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("block took an item while busy");

  a_no_pick_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.found) |->
      (out_item_o.chosen_slot == '0 && out_item_o.chosen_deadline == '0))
    else $error("pick fields set without a found slot");

  a_nice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.prev_nice <= eevdf_pkg::NICE_MAX))
    else $error("previous nice out of range");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == eevdf_pkg::S_DIV && cnt_q == DIV_LAST) |=> (state_q == eevdf_pkg::S_WR))
    else $error("divider did not finish on time");

endmodule

@@ tb/sv/tb_eevdf_task_picker.sv @@
`timescale 1ns / 1ps

module tb_eevdf_task_picker;

  localparam int unsigned NSLOT = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  eevdf_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  eevdf_pkg::out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  eevdf_task_picker #(.SLOTS(NSLOT)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scheduler state as the testbench sees it.
  eevdf_pkg::status_e                sched_status[NSLOT];
  logic [eevdf_pkg::NICE_W-1:0]      sched_nice[NSLOT];
  logic [eevdf_pkg::VR_W-1:0]        sched_vr[NSLOT];
  logic [eevdf_pkg::DL_W-1:0]        sched_dl[NSLOT];
  logic [7:0]         slice_len;
  longint unsigned    nice_weight[40] = '{
    88818, 71054, 56843, 45475, 36380, 29104, 23283, 18626, 14901, 11921,
    9537, 7629, 6104, 4883, 3906, 3125, 2500, 2000, 1600, 1280,
    1024, 819, 655, 524, 419, 336, 268, 215, 172, 137,
    110, 88, 70, 56, 45, 36, 29, 23, 18, 15};

  eevdf_pkg::in_item_t  pending_items[$];
  eevdf_pkg::out_item_t awaited_results[$];
  int        fail_count = 0;
  logic      in_fire = 1'b0;

  function automatic eevdf_pkg::in_item_t make_item(eevdf_pkg::op_e op, int slot,
                                                    logic [31:0] vr,
                                                    eevdf_pkg::status_e st, bit refr,
                                                    int nl);
    eevdf_pkg::in_item_t it;
    it.op = op;
    it.slot = slot[5:0];
    it.vruntime = vr;
    it.status = st;
    it.refresh_deadline = refr;
    it.nice_level = nl[5:0];
    return it;
  endfunction

  function automatic logic [eevdf_pkg::DL_W-1:0] fresh_deadline(int s);
    longint unsigned span;
    span = (longint'(slice_len) * 1024) / nice_weight[sched_nice[s]];
    return eevdf_pkg::DL_W'(longint'(sched_vr[s]) + span);
  endfunction

  function automatic bit is_active(int s);
    return sched_status[s] == eevdf_pkg::ST_RUNNING ||
           sched_status[s] == eevdf_pkg::ST_RUNNABLE;
  endfunction

  function automatic eevdf_pkg::out_item_t schedule_step(eevdf_pkg::in_item_t it);
    eevdf_pkg::out_item_t r;
    int s;
    logic [5:0] nl;
    eevdf_pkg::status_e prev;
    longint unsigned minv, wsum, lag;
    bit any, have;
    int best;
    r = '0;
    s = it.slot;
    case (eevdf_pkg::op_e'(it.op))
      eevdf_pkg::OP_SET_VRUNTIME: sched_vr[s] = it.vruntime;
      eevdf_pkg::OP_SET_STATUS: begin
        prev = sched_status[s];
        sched_status[s] = eevdf_pkg::status_e'(it.status);
        if ((prev == eevdf_pkg::ST_SLEEPING && it.status == eevdf_pkg::ST_RUNNABLE) ||
            it.refresh_deadline)
          sched_dl[s] = fresh_deadline(s);
      end
      eevdf_pkg::OP_SET_NICE: begin
        r.prev_nice = sched_nice[s];
        nl = (it.nice_level > eevdf_pkg::NICE_MAX) ? eevdf_pkg::NICE_MAX : it.nice_level;
        sched_nice[s] = nl;
        sched_dl[s] = fresh_deadline(s);
      end
      default: begin
        minv = '1; wsum = 0; lag = 0; any = 0; have = 0; best = 0;
        for (int i = 0; i < NSLOT; i++)
          if (is_active(i)) begin
            any = 1;
            wsum += nice_weight[sched_nice[i]];
            if (sched_vr[i] < minv) minv = sched_vr[i];
          end
        if (!any) minv = 0;
        for (int i = 0; i < NSLOT; i++)
          if (is_active(i)) lag += nice_weight[sched_nice[i]] * (sched_vr[i] - minv);
        for (int i = 0; i < NSLOT; i++)
          if (sched_status[i] == eevdf_pkg::ST_RUNNABLE &&
              (wsum == 0 || (sched_vr[i] - minv) * wsum <= lag) &&
              (!have || sched_dl[i] < sched_dl[best])) begin
            best = i;
            have = 1;
          end
        if (have) begin
          sched_status[best] = eevdf_pkg::ST_RUNNING;
          r.found = 1'b1;
          r.chosen_slot = best[5:0];
          r.chosen_deadline = sched_dl[best];
        end
      end
    endcase
    return r;
  endfunction

  // Monitor: predicts on each accepted input item, checks each accepted result.
  always @(posedge clk_i) begin
    eevdf_pkg::out_item_t want;
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o)
      awaited_results.push_back(schedule_step(in_item_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result item");
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_item_o.found !== want.found) begin
          $error("found: expected %0d actual %0d", want.found, out_item_o.found);
          fail_count++;
        end
        if (out_item_o.chosen_slot !== want.chosen_slot) begin
          $error("chosen_slot: expected %0d actual %0d", want.chosen_slot,
                 out_item_o.chosen_slot);
          fail_count++;
        end
        if (out_item_o.prev_nice !== want.prev_nice) begin
          $error("prev_nice: expected %0d actual %0d", want.prev_nice,
                 out_item_o.prev_nice);
          fail_count++;
        end
        if (out_item_o.chosen_deadline !== want.chosen_deadline) begin
          $error("chosen_deadline: expected %0d actual %0d", want.chosen_deadline,
                 out_item_o.chosen_deadline);
          fail_count++;
        end
      end
    end
  end

  // Driver: bursts of items separated by random gaps.
  int burst_left = 4;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off so the block backs up.
  int stall_cycle = 0;
  always @(negedge clk_i) begin
    stall_cycle++;
    if (stall_cycle >= 3000 && stall_cycle < 3800)
      out_stall_i <= 1'b1;
    else
      case ((stall_cycle >> 7) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= stall_cycle[1];
      endcase
  end

  task automatic write_slice(logic [7:0] val);
    @(negedge clk_i);
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    slice_len = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || awaited_results.size() > 0)
      @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  function automatic eevdf_pkg::in_item_t random_item(logic [31:0] base);
    int slot;
    int roll;
    logic [31:0] vr;
    slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
    vr = ($urandom_range(0, 4) == 0) ? $urandom() : base + $urandom_range(0, 3000);
    roll = $urandom_range(0, 99);
    if (roll < 20)
      return make_item(eevdf_pkg::OP_SET_VRUNTIME, slot, vr,
                       eevdf_pkg::status_e'($urandom_range(0, 3)),
                       $urandom_range(0, 1), $urandom_range(0, 63));
    if (roll < 50)
      return make_item(eevdf_pkg::OP_SET_STATUS, slot, $urandom(),
                       ($urandom_range(0, 2) == 0) ?
                         eevdf_pkg::status_e'($urandom_range(0, 3)) :
                         eevdf_pkg::ST_RUNNABLE,
                       $urandom_range(0, 1), $urandom_range(0, 63));
    if (roll < 65)
      return make_item(eevdf_pkg::OP_SET_NICE, slot, $urandom(),
                       eevdf_pkg::status_e'($urandom_range(0, 3)),
                       $urandom_range(0, 1),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(40, 63)
                                                   : $urandom_range(0, 39));
    return make_item(eevdf_pkg::OP_PICK, slot, $urandom(),
                     eevdf_pkg::status_e'($urandom_range(0, 3)),
                     $urandom_range(0, 1), $urandom_range(0, 63));
  endfunction

  logic [7:0] slice_plan[6] = '{8'd1, 8'd255, 8'd0, 8'd5, 8'd128, 8'd37};

  initial begin
    logic [31:0] base;
    slice_len = eevdf_pkg::SLICE_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      sched_status[i] = eevdf_pkg::ST_INACTIVE;
      sched_nice[i] = eevdf_pkg::NICE_DEFAULT;
      sched_vr[i] = '0;
      sched_dl[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty pick, field extremes, wake from sleep, saturation, ties.
    pending_items.push_back(make_item(eevdf_pkg::OP_PICK, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_VRUNTIME, 0, 32'd0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_VRUNTIME, 63, 32'hFFFF_FFFF,
                                      eevdf_pkg::ST_RUNNING, 1, 63));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_VRUNTIME, 1, 32'd100,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_NICE, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_NICE, 63, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 39));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_NICE, 1, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 63));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 63, 0,
                                      eevdf_pkg::ST_SLEEPING, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 63, 0,
                                      eevdf_pkg::ST_RUNNABLE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 0, 0,
                                      eevdf_pkg::ST_RUNNABLE, 1, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 1, 0,
                                      eevdf_pkg::ST_RUNNABLE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_PICK, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_PICK, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_VRUNTIME, 2, 32'd50,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_VRUNTIME, 3, 32'd50,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 3, 0,
                                      eevdf_pkg::ST_RUNNABLE, 1, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 2, 0,
                                      eevdf_pkg::ST_RUNNABLE, 1, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_PICK, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_PICK, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_SET_STATUS, 2, 0,
                                      eevdf_pkg::ST_RUNNABLE, 0, 0));
    pending_items.push_back(make_item(eevdf_pkg::OP_PICK, 0, 0,
                                      eevdf_pkg::ST_INACTIVE, 0, 0));
    drain();

    foreach (slice_plan[p]) begin
      write_slice(slice_plan[p]);
      base = (p % 2) ? $urandom() : $urandom_range(0, 5000);
      for (int n = 0; n < 125; n++)
        pending_items.push_back(random_item(base));
      drain();
    end

    if (fail_count == 0)
      $display("eevdf_task_picker: match");
    else
      $display("eevdf_task_picker: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("eevdf_task_picker: mismatch");
    $finish;
  end

endmodule
